FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file. They expect clk and rst_n
// in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define LFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define LFR_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Types and constants of the letter frequency ranker.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int NUM_LETTERS  = 26;
  localparam int LETTER_BITS  = 5;
  localparam int OUT_CNT_BITS = 16;
  localparam int PCT_BITS     = 14;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [LETTER_BITS-1:0] LAST_LETTER = 5'd25;
  localparam logic [PCT_BITS-1:0]    PCT_SCALE   = 14'd10000;

  // ASCII letter range limits
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       finish;
  } lfr_in_t;

  typedef struct packed {
    logic [LETTER_BITS-1:0]  letter;
    logic [OUT_CNT_BITS-1:0] count;
    logic [PCT_BITS-1:0]     percent_hundredths;
    logic                    last;
  } lfr_out_t;

  // Command passed from the front to the back through the queue
  typedef struct packed {
    logic                   is_finish;
    logic [LETTER_BITS-1:0] letter;
  } lfr_cmd_t;

endpackage

FILE: src/lfr_front.sv
// ----------------------------------------------------------------------------
// lfr_front
// Accepts input transactions and classifies each byte: a letter or a finish
// becomes a queued command, any other byte is dropped here.
// ----------------------------------------------------------------------------
module lfr_front (
  input  logic              start,
  input  logic              q_full,
  input  lfr_pkg::lfr_in_t  in_item,
  output logic              push,
  output lfr_pkg::lfr_cmd_t push_cmd
);

  logic       is_upper;
  logic       is_lower;
  logic [7:0] upper_off;
  logic [7:0] lower_off;

  // Letter detection, case folded
  assign is_upper  = (in_item.char_byte >= lfr_pkg::CHAR_UPPER_A) &&
                     (in_item.char_byte <= lfr_pkg::CHAR_UPPER_Z);
  assign is_lower  = (in_item.char_byte >= lfr_pkg::CHAR_LOWER_A) &&
                     (in_item.char_byte <= lfr_pkg::CHAR_LOWER_Z);
  assign upper_off = in_item.char_byte - lfr_pkg::CHAR_UPPER_A;
  assign lower_off = in_item.char_byte - lfr_pkg::CHAR_LOWER_A;

  // Queue a command for letters and finish only
  assign push = start && !q_full && (in_item.finish || is_upper || is_lower);

  assign push_cmd.is_finish = in_item.finish;
  assign push_cmd.letter    = is_upper ? upper_off[lfr_pkg::LETTER_BITS-1:0]
                                       : lower_off[lfr_pkg::LETTER_BITS-1:0];

endmodule

FILE: src/lfr_queue.sv
// ----------------------------------------------------------------------------
// lfr_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module lfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lfr_pkg::lfr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output lfr_pkg::lfr_cmd_t pop_cmd
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  lfr_pkg::lfr_cmd_t   slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] fill_r;

  assign full    = (fill_r == CNT_BITS'(DEPTH));
  assign valid   = (fill_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_BITS'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_BITS'(1);
      end
    end
  end

endmodule

FILE: src/lfr_div.sv
// ----------------------------------------------------------------------------
// lfr_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QUO_BITS.
// ----------------------------------------------------------------------------
module lfr_div #(
  parameter int NUM_BITS = 30,
  parameter int DEN_BITS = 16,
  parameter int QUO_BITS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                done,
  output logic [QUO_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(QUO_BITS);

  logic [NUM_BITS-1:0]  rem_r;
  logic [NUM_BITS-1:0]  den_r;
  logic [QUO_BITS-1:0]  quo_r;
  logic [STEP_BITS-1:0] step_r;
  logic                 run_r;
  logic                 done_r;
  logic                 ge;

  assign ge       = (rem_r >= den_r);
  assign done     = done_r;
  assign quotient = quo_r;

  // Shift-subtract sequence, MSB of the quotient first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        den_r  <= NUM_BITS'(divisor) << (QUO_BITS - 1);
        quo_r  <= '0;
        step_r <= STEP_BITS'(QUO_BITS - 1);
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (ge) begin
          rem_r <= rem_r - den_r;
        end
        quo_r <= {quo_r[QUO_BITS-2:0], ge};
        den_r <= den_r >> 1;
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_BITS'(1);
        end
      end
    end
  end

endmodule

FILE: src/lfr_back.sv
// ----------------------------------------------------------------------------
// lfr_back
// Holds the letter counters. Applies queued letter commands and, on finish,
// ranks the letters by repeated max scans and emits one result per scan.
// ----------------------------------------------------------------------------
module lfr_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  lfr_pkg::lfr_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  output lfr_pkg::lfr_out_t out_item
);

  localparam int PROD_BITS = COUNT_BITS + lfr_pkg::PCT_BITS;
  localparam int LB        = lfr_pkg::LETTER_BITS;
  localparam int NL        = lfr_pkg::NUM_LETTERS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV
  } state_t;

  state_t                      state_r;
  logic [COUNT_BITS-1:0]       cnt_mem [NL];
  logic [NL-1:0]               cnt_vld_r;
  logic [COUNT_BITS-1:0]       total_r;
  logic [NL-1:0]               emitted_r;
  logic [LB-1:0]               scan_idx_r;
  logic [LB-1:0]               rank_r;
  logic                        best_ok_r;
  logic [LB-1:0]               best_idx_r;
  logic [COUNT_BITS-1:0]       best_cnt_r;
  logic [PROD_BITS-1:0]        prod_r;
  logic                        div_go_r;
  logic                        out_valid_r;
  lfr_pkg::lfr_out_t           out_item_r;

  logic [LB-1:0]               rd_idx;
  logic [COUNT_BITS-1:0]       rd_cnt;
  logic [COUNT_BITS-1:0]       inc_cnt;
  logic [COUNT_BITS-1:0]       total_inc;
  logic                        do_inc;
  logic                        take;
  logic                        div_done;
  logic [lfr_pkg::PCT_BITS-1:0] div_quo;
  logic [COUNT_BITS+lfr_pkg::OUT_CNT_BITS-1:0] cnt_ext;

  // Counter read port, shared by increment and scan
  assign rd_idx    = (state_r == ST_IDLE) ? q_cmd.letter : scan_idx_r;
  assign rd_cnt    = cnt_vld_r[rd_idx] ? cnt_mem[rd_idx] : '0;
  assign inc_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign total_inc = (total_r == '1) ? total_r : total_r + COUNT_BITS'(1);

  assign q_pop  = (state_r == ST_IDLE) && q_valid;
  assign do_inc = q_pop && !q_cmd.is_finish;

  // Strictly greater keeps the earlier letter on ties
  assign take = !emitted_r[scan_idx_r] && (!best_ok_r || (rd_cnt > best_cnt_r));

  assign cnt_ext   = {{lfr_pkg::OUT_CNT_BITS{1'b0}}, best_cnt_r};
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Share of total, count * 10000 / total
  lfr_div #(
    .NUM_BITS (PROD_BITS),
    .DEN_BITS (COUNT_BITS),
    .QUO_BITS (lfr_pkg::PCT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (prod_r),
    .divisor  (total_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Counter storage
  always_ff @(posedge clk) begin
    if (do_inc) begin
      cnt_mem[q_cmd.letter] <= inc_cnt;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_vld_r   <= '0;
      total_r     <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_cmd.is_finish) begin
              emitted_r  <= '0;
              rank_r     <= '0;
              scan_idx_r <= '0;
              best_ok_r  <= 1'b0;
              state_r    <= ST_SCAN;
            end else begin
              cnt_vld_r[q_cmd.letter] <= 1'b1;
              total_r                 <= total_inc;
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            best_ok_r  <= 1'b1;
            best_idx_r <= scan_idx_r;
            best_cnt_r <= rd_cnt;
          end
          if (scan_idx_r == lfr_pkg::LAST_LETTER) begin
            state_r <= ST_MUL;
          end else begin
            scan_idx_r <= scan_idx_r + LB'(1);
          end
        end
        ST_MUL: begin
          prod_r   <= PROD_BITS'(best_cnt_r) * PROD_BITS'(lfr_pkg::PCT_SCALE);
          div_go_r <= 1'b1;
          state_r  <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid_r                   <= 1'b1;
            out_item_r.letter             <= best_idx_r;
            out_item_r.count              <= cnt_ext[lfr_pkg::OUT_CNT_BITS-1:0];
            out_item_r.percent_hundredths <= (total_r == '0) ? '0 : div_quo;
            out_item_r.last               <= (rank_r == lfr_pkg::LAST_LETTER);
            emitted_r[best_idx_r]         <= 1'b1;
            if (rank_r == lfr_pkg::LAST_LETTER) begin
              // Table done: clear the histogram
              cnt_vld_r <= '0;
              total_r   <= '0;
              state_r   <= ST_IDLE;
            end else begin
              rank_r     <= rank_r + LB'(1);
              scan_idx_r <= '0;
              best_ok_r  <= 1'b0;
              state_r    <= ST_SCAN;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/letter_frequency_ranker_top.sv
// ----------------------------------------------------------------------------
// letter_frequency_ranker_top: letter histogram emitted in descending order.
// Bytes: one per cycle while busy is low; a letter passes through the command queue
// before it reaches the counters. Finish: 26 results, one after another; each needs a
// letter scan, a multiply, a divider load, the divide steps and an output register.
// Sync active-low reset clears counters and queue; results cannot be stalled.
// ----------------------------------------------------------------------------
module letter_frequency_ranker_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lfr_pkg::lfr_in_t  in_item,
  output logic              out_valid,
  output lfr_pkg::lfr_out_t out_item
);

  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  lfr_pkg::lfr_cmd_t push_cmd;
  lfr_pkg::lfr_cmd_t q_cmd;

  assign busy = q_full;

  // Classify incoming bytes
  lfr_front u_front (
    .start    (start),
    .q_full   (q_full),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decoupling queue
  lfr_queue #(
    .DEPTH (lfr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  // Counters and ranking
  lfr_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: src/lfr_checker.sv
// ----------------------------------------------------------------------------
// lfr_checker
// Port-level checks on the letter frequency ranker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input lfr_pkg::lfr_in_t  in_item,
  input logic              out_valid,
  input lfr_pkg::lfr_out_t out_item
);

  // Result fields stay in range
  `LFR_ASSERT(a_letter_range, out_valid |-> (out_item.letter <= lfr_pkg::LAST_LETTER), "letter index out of range")
  `LFR_ASSERT(a_pct_range, out_valid |-> (out_item.percent_hundredths <= lfr_pkg::PCT_SCALE), "share above 100 percent")

  // Each ranked result needs a full scan, so strobes never come back to back
  `LFR_ASSERT(a_strobe_gap, out_valid |=> !out_valid, "result strobes on adjacent cycles")

  // Reset leaves the block empty and ready
  `LFR_ASSERT_NR(a_reset_idle, !rst_n |=> (!out_valid && !busy), "block not idle after reset")

endmodule

bind letter_frequency_ranker_top lfr_checker u_lfr_checker (.*);

FILE: dv/letter_frequency_ranker_top_tb.sv
// ----------------------------------------------------------------------------
// letter_frequency_ranker_top_tb
// Self-checking bench for the letter frequency ranker. A text stream of bytes
// and finish transactions is driven through the start/busy handshake. A
// built-in letter tally predicts the 26 ranked rows of each finish, and every
// row that the block strobes out is checked field by field. The stimulus has
// two parts: directed edge cases and random text blocks.
// ----------------------------------------------------------------------------
module letter_frequency_ranker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_BITS      = 16;
  localparam int RANDOM_ITEMS  = 320;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 120;

  // One queued byte, with the idle cycles to insert before it
  typedef struct packed {
    lfr_pkg::lfr_in_t item;
    int unsigned      gap;
  } text_slot_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  lfr_pkg::lfr_in_t  in_item = '0;
  logic              out_valid;
  lfr_pkg::lfr_out_t out_item;

  letter_frequency_ranker_top #(
    .COUNT_BITS(CNT_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Letter tally kept by the bench
  logic [CNT_BITS-1:0] tally [lfr_pkg::NUM_LETTERS];
  logic [CNT_BITS-1:0] letter_total;
  lfr_pkg::lfr_out_t   expected_ranking [$];
  text_slot_t          text_q [$];

  int unsigned       queued_cnt   = 0;
  int unsigned       accepted_cnt = 0;
  int unsigned       finish_cnt   = 0;
  int unsigned       rows_checked = 0;
  int unsigned       err_cnt      = 0;
  int unsigned       cycle_cnt    = 0;
  bit                quiet        = 1'b0;
  bit                taken        = 1'b0;
  bit                have_cur     = 1'b0;
  text_slot_t        cur;
  lfr_pkg::lfr_out_t exp_row;

  // Count a byte, or rank and clear on finish
  task automatic tally_byte(input lfr_pkg::lfr_in_t it);
    int order [lfr_pkg::NUM_LETTERS];
    int idx;
    int j;
    longint share;
    lfr_pkg::lfr_out_t row;
    idx = -1;
    if (!it.finish) begin
      if (it.char_byte >= lfr_pkg::CHAR_UPPER_A && it.char_byte <= lfr_pkg::CHAR_UPPER_Z)
        idx = int'(it.char_byte - lfr_pkg::CHAR_UPPER_A);
      else if (it.char_byte >= lfr_pkg::CHAR_LOWER_A && it.char_byte <= lfr_pkg::CHAR_LOWER_Z)
        idx = int'(it.char_byte - lfr_pkg::CHAR_LOWER_A);
      if (idx >= 0) begin
        if (tally[idx] != '1) tally[idx]++;
        if (letter_total != '1) letter_total++;
      end
    end else begin
      // stable insertion sort: higher count first, ties stay alphabetical
      for (int i = 0; i < lfr_pkg::NUM_LETTERS; i++) begin
        j = i;
        while (j > 0 && tally[order[j-1]] < tally[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (int i = 0; i < lfr_pkg::NUM_LETTERS; i++) begin
        share = 0;
        if (letter_total != 0)
          share = (longint'(tally[order[i]]) * longint'(lfr_pkg::PCT_SCALE)) /
                  longint'(letter_total);
        row.letter             = order[i][lfr_pkg::LETTER_BITS-1:0];
        row.count              = tally[order[i]][lfr_pkg::OUT_CNT_BITS-1:0];
        row.percent_hundredths = share[lfr_pkg::PCT_BITS-1:0];
        row.last               = (i == lfr_pkg::NUM_LETTERS - 1);
        expected_ranking = {expected_ranking, row};
      end
      for (int i = 0; i < lfr_pkg::NUM_LETTERS; i++) tally[i] = '0;
      letter_total = '0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic fin, input int unsigned gap);
    text_slot_t s;
    s.item.char_byte = b;
    s.item.finish    = fin;
    s.gap            = gap;
    text_q = {text_q, s};
    queued_cnt++;
  endtask

  function automatic logic [7:0] rand_letter(input int idx);
    return ($urandom_range(0, 1) ? lfr_pkg::CHAR_UPPER_A : lfr_pkg::CHAR_LOWER_A) + 8'(idx);
  endfunction

  // Driver: presents queued bytes at the falling edge, holds until accepted
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || taken) begin
        taken = 1'b0;
        if (!have_cur && text_q.size() > 0) begin
          cur = text_q.pop_front();
          have_cur = 1'b1;
        end
        if (have_cur && cur.gap == 0) begin
          start   <= 1'b1;
          in_item <= cur.item;
          have_cur = 1'b0;
        end else begin
          start <= 1'b0;
          if (have_cur) cur.gap--;
        end
      end
    end
  end

  // Monitor: records accepted transactions and checks strobed rows
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        tally_byte(in_item);
        if (in_item.finish) finish_cnt++;
        accepted_cnt++;
        taken = 1'b1;
      end
      if (out_valid) begin
        if (expected_ranking.size() == 0) begin
          err_cnt++;
          $error("unexpected row: letter %0d count %0d", out_item.letter, out_item.count);
        end else begin
          exp_row = expected_ranking.pop_front();
          rows_checked++;
          if (out_item.letter !== exp_row.letter) begin
            err_cnt++;
            $error("letter: expected %0d, got %0d", exp_row.letter, out_item.letter);
          end
          if (out_item.count !== exp_row.count) begin
            err_cnt++;
            $error("count: expected %0d, got %0d", exp_row.count, out_item.count);
          end
          if (out_item.percent_hundredths !== exp_row.percent_hundredths) begin
            err_cnt++;
            $error("percent_hundredths: expected %0d, got %0d",
                   exp_row.percent_hundredths, out_item.percent_hundredths);
          end
          if (out_item.last !== exp_row.last) begin
            err_cnt++;
            $error("last: expected %0b, got %0b", exp_row.last, out_item.last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still pending",
               cycle_cnt, expected_ranking.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned rand_cnt;
    int unsigned len;
    int unsigned pick;
    int subset [3];
    bit narrow;
    rand_cnt = 0;
    for (int i = 0; i < lfr_pkg::NUM_LETTERS; i++) tally[i] = '0;
    letter_total = '0;

    // Empty text right after reset: all zero, A to Z order
    queue_byte(8'h00, 1'b1, 0);

    // Letter range edges, both cases, high-bit bytes and ties
    queue_byte(lfr_pkg::CHAR_UPPER_A, 1'b0, 0);
    queue_byte(lfr_pkg::CHAR_UPPER_Z, 1'b0, 1);
    queue_byte(lfr_pkg::CHAR_LOWER_A, 1'b0, 0);
    queue_byte(lfr_pkg::CHAR_LOWER_Z, 1'b0, 0);
    queue_byte(8'h40, 1'b0, 2);
    queue_byte(8'h5B, 1'b0, 0);
    queue_byte(8'h60, 1'b0, 0);
    queue_byte(8'h7B, 1'b0, 0);
    queue_byte(8'h00, 1'b0, 0);
    queue_byte(8'hFF, 1'b0, 7);
    queue_byte(8'h80, 1'b0, 0);
    queue_byte(8'hC1, 1'b0, 0);
    queue_byte(8'hE1, 1'b0, 0);
    queue_byte(8'h4D, 1'b0, 0);
    queue_byte(8'h6D, 1'b0, 0);
    queue_byte(8'h71, 1'b0, 0);
    queue_byte(8'h51, 1'b0, 0);
    queue_byte(8'h51, 1'b0, 0);
    // finish carrying a letter byte: the byte must be ignored
    queue_byte(lfr_pkg::CHAR_LOWER_A, 1'b1, 0);

    // Uneven counts, with one letter given in both cases
    for (int i = 0; i < 3; i++) queue_byte(lfr_pkg::CHAR_LOWER_A + 8'd1, 1'b0, 0);
    queue_byte(lfr_pkg::CHAR_UPPER_A + 8'd2, 1'b0, 0);
    queue_byte(lfr_pkg::CHAR_LOWER_A + 8'd2, 1'b0, 0);
    queue_byte(8'hFF, 1'b1, 0);
    // counters must be clear again
    queue_byte(8'h00, 1'b1, 3);

    // Random text blocks, most ended by a finish
    while (rand_cnt < RANDOM_ITEMS) begin
      quiet  = ($urandom_range(0, 3) == 0);
      narrow = $urandom_range(0, 1);
      for (int k = 0; k < 3; k++) subset[k] = $urandom_range(0, lfr_pkg::NUM_LETTERS - 1);
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          queue_byte(rand_letter(narrow ? subset[$urandom_range(0, 2)]
                                        : $urandom_range(0, lfr_pkg::NUM_LETTERS - 1)),
                     1'b0, pick_gap());
        end else begin
          queue_byte(8'($urandom_range(0, 255)), 1'b0, pick_gap());
        end
        rand_cnt++;
      end
      // now and then a block runs on into the next one without a finish
      if ($urandom_range(0, 9) != 0) begin
        queue_byte(8'($urandom_range(0, 255)), 1'b1, pick_gap());
        rand_cnt++;
      end
    end
    queue_byte(8'($urandom_range(0, 255)), 1'b1, 0);

    // Reset
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Drain
    while (accepted_cnt != queued_cnt) @(posedge clk);
    while (expected_ranking.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d text transactions including %0d finish transactions,",
             accepted_cnt, finish_cnt);
    $display("with letter edges, non-letter bytes and ties, and checked %0d ranked rows.",
             rows_checked);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/lfr_pkg.sv
src/lfr_front.sv
src/lfr_queue.sv
src/lfr_div.sv
src/lfr_back.sv
src/letter_frequency_ranker_top.sv
src/lfr_checker.sv
dv/letter_frequency_ranker_top_tb.sv
